FILE: rtl/dihed_pkg.sv
// Shared types, widths and constants for the dihedral angle unit.
// No dependencies; every other file imports this package.
package dihed_pkg;

	// Field widths
	localparam int CW = 16;        // far/near component width
	localparam int AW = 16;        // axis component width
	localparam int AXIS_ONE = 16384;

	// Intermediate widths
	localparam int PW   = CW + AW;          // component product
	localparam int XAW  = CW + AW + 1;      // cross component with axis
	localparam int FNPW = 2 * CW;           // far-near product
	localparam int CXW  = 2 * CW + 1;       // far x near component
	localparam int DFW  = CW + AW + 2;      // dot product with axis
	localparam int FNW  = 2 * CW + 2;       // far . near
	localparam int SPW  = CXW + AW;         // (f x n)_k * a_k
	localparam int DDW  = 2 * DFW;          // df * dn
	localparam int WIDE = 2 * CW + 2 * AW + 5;

	// Arctangent datapath
	localparam int LIM_BITS = 40;           // operands scaled below 2^40
	localparam int KW = $clog2(WIDE - LIM_BITS + 1);
	localparam int XW = LIM_BITS + 3;
	localparam int ZW = 25;
	localparam int TW = 24;
	localparam int MAX_ITER = 24;

	localparam logic signed [ZW-1:0] DEG90_Z = ZW'(90 * 65536);
	localparam logic [TW-1:0] DEG90_T  = TW'(90 * 65536);
	localparam logic [TW-1:0] DEG180_T = TW'(180 * 65536);
	localparam logic [15:0] ANG_MAX = 16'd23040;
	localparam logic [TW:0] ROUND_HALF = (TW+1)'(256);

	// Cyclic index partners for cross products
	localparam int K1 [3] = '{1, 2, 0};
	localparam int K2 [3] = '{2, 0, 1};

	typedef struct packed {
		logic signed [AW-1:0] axis_x;
		logic signed [AW-1:0] axis_y;
		logic signed [AW-1:0] axis_z;
		logic signed [CW-1:0] far_x;
		logic signed [CW-1:0] far_y;
		logic signed [CW-1:0] far_z;
		logic signed [CW-1:0] near_x;
		logic signed [CW-1:0] near_y;
		logic signed [CW-1:0] near_z;
	} item_t;

	typedef struct packed {
		logic signed [15:0] angle_deg;
		logic               degenerate;
	} result_t;

	typedef struct packed {
		logic degenerate;
		logic sn_zero;
		logic sn_pos;
		logic cs_zero;
		logic cs_neg;
	} flags_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic logic signed [ZW-1:0] atan_deg16(input int idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			0:  v = ZW'(2949120);
			1:  v = ZW'(1740967);
			2:  v = ZW'(919879);
			3:  v = ZW'(466945);
			4:  v = ZW'(234379);
			5:  v = ZW'(117304);
			6:  v = ZW'(58666);
			7:  v = ZW'(29335);
			8:  v = ZW'(14668);
			9:  v = ZW'(7334);
			10: v = ZW'(3667);
			11: v = ZW'(1833);
			12: v = ZW'(917);
			13: v = ZW'(458);
			14: v = ZW'(229);
			15: v = ZW'(115);
			16: v = ZW'(57);
			17: v = ZW'(29);
			18: v = ZW'(14);
			19: v = ZW'(7);
			20: v = ZW'(4);
			21: v = ZW'(2);
			22: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/dihedral_angle_about_axis_unit.sv
// Top level of the dihedral angle unit: front end, CORDIC, output stage.
// Depends on dihed_pkg, dihed_front, dihed_cordic and dihed_back.
//
//   channel   | signals                          | direction
//   ----------+----------------------------------+----------
//   item      | item_valid, item_ready, item     | in
//   result    | result_valid, result_ready, result| out
//
// One transaction enters per cycle while item_ready is high; the pipeline is
// seven front stages, one stage per CORDIC rotation and the output register.
// Reset clears only the valid bits of every stage; no clearing pass is needed.
// A stall on result holds full stages and lets upstream bubbles close up, so
// item_ready stays high while any stage is empty.
module dihedral_angle_about_axis_unit #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  dihed_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_ready,
	output dihed_pkg::result_t  result
);
	import dihed_pkg::*;

	logic                 fc_valid, fc_ready;
	logic signed [XW-1:0] fc_x, fc_y;
	flags_t               fc_flags;
	logic                 cb_valid, cb_ready;
	logic signed [ZW-1:0] cb_z;
	flags_t               cb_flags;

	dihed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (item_valid),
		.up_ready (item_ready),
		.up_data  (item),
		.dn_valid (fc_valid),
		.dn_ready (fc_ready),
		.dn_x     (fc_x),
		.dn_y     (fc_y),
		.dn_flags (fc_flags)
	);

	dihed_cordic #(
		.ITER (ANGLE_ITERATIONS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fc_valid),
		.up_ready (fc_ready),
		.up_x     (fc_x),
		.up_y     (fc_y),
		.up_flags (fc_flags),
		.dn_valid (cb_valid),
		.dn_ready (cb_ready),
		.dn_z     (cb_z),
		.dn_flags (cb_flags)
	);

	dihed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cb_valid),
		.up_ready (cb_ready),
		.up_z     (cb_z),
		.up_flags (cb_flags),
		.dn_valid (result_valid),
		.dn_ready (result_ready),
		.dn_data  (result)
	);

endmodule

FILE: rtl/dihed_front.sv
// Front end: products, sine/cosine assembly, magnitudes and prescaling.
// Seven pipeline stages; depends on dihed_pkg.
module dihed_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  dihed_pkg::item_t              up_data,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic signed [dihed_pkg::XW-1:0] dn_x,
	output logic signed [dihed_pkg::XW-1:0] dn_y,
	output dihed_pkg::flags_t             dn_flags
);
	import dihed_pkg::*;

	localparam int NS = 7;

	logic [NS-1:0] vld_q;
	logic [NS:0]   adv;

	always_comb begin
		adv[NS] = dn_ready;
		for (int i = NS - 1; i >= 0; i--) begin
			adv[i] = ~vld_q[i] | adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (adv[i]) begin
					vld_q[i] <= (i == 0) ? up_valid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign up_ready = adv[0];
	assign dn_valid = vld_q[NS-1];

	// Clamp axis, unpack vectors
	logic signed [AW-1:0] a_c [3];
	logic signed [AW-1:0] a_raw [3];
	logic signed [CW-1:0] f_c [3];
	logic signed [CW-1:0] n_c [3];

	always_comb begin
		a_raw[0] = up_data.axis_x;
		a_raw[1] = up_data.axis_y;
		a_raw[2] = up_data.axis_z;
		f_c[0] = up_data.far_x;
		f_c[1] = up_data.far_y;
		f_c[2] = up_data.far_z;
		n_c[0] = up_data.near_x;
		n_c[1] = up_data.near_y;
		n_c[2] = up_data.near_z;
		for (int k = 0; k < 3; k++) begin
			if (a_raw[k] > $signed(AW'(AXIS_ONE))) begin
				a_c[k] = AW'(AXIS_ONE);
			end else if (a_raw[k] < -$signed(AW'(AXIS_ONE))) begin
				a_c[k] = -$signed(AW'(AXIS_ONE));
			end else begin
				a_c[k] = a_raw[k];
			end
		end
	end

	// Stage 1: all component products
	logic signed [PW-1:0]   fa1_s1 [3], fa2_s1 [3], na1_s1 [3], na2_s1 [3];
	logic signed [FNPW-1:0] fn1_s1 [3], fn2_s1 [3], fnd_s1 [3];
	logic signed [PW-1:0]   fad_s1 [3], nad_s1 [3];
	logic signed [AW-1:0]   a_s1 [3];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int k = 0; k < 3; k++) begin
				fa1_s1[k] <= f_c[K1[k]] * a_c[K2[k]];
				fa2_s1[k] <= f_c[K2[k]] * a_c[K1[k]];
				na1_s1[k] <= n_c[K1[k]] * a_c[K2[k]];
				na2_s1[k] <= n_c[K2[k]] * a_c[K1[k]];
				fn1_s1[k] <= f_c[K1[k]] * n_c[K2[k]];
				fn2_s1[k] <= f_c[K2[k]] * n_c[K1[k]];
				fad_s1[k] <= f_c[k] * a_c[k];
				nad_s1[k] <= n_c[k] * a_c[k];
				fnd_s1[k] <= f_c[k] * n_c[k];
				a_s1[k]   <= a_c[k];
			end
		end
	end

	// Stage 2: cross components, dots, degenerate test
	logic signed [XAW-1:0] fax [3], nax [3];
	logic                  far_par, near_par;
	logic signed [CXW-1:0] cx_s2 [3];
	logic signed [DFW-1:0] df_s2, dn_s2;
	logic signed [FNW-1:0] fn_s2;
	logic signed [AW-1:0]  a_s2 [3];
	logic                  deg_s2;

	always_comb begin
		far_par = 1'b1;
		near_par = 1'b1;
		for (int k = 0; k < 3; k++) begin
			fax[k] = XAW'(fa1_s1[k]) - XAW'(fa2_s1[k]);
			nax[k] = XAW'(na1_s1[k]) - XAW'(na2_s1[k]);
			if (fax[k] != '0) far_par = 1'b0;
			if (nax[k] != '0) near_par = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int k = 0; k < 3; k++) begin
				cx_s2[k] <= CXW'(fn1_s1[k]) - CXW'(fn2_s1[k]);
				a_s2[k]  <= a_s1[k];
			end
			df_s2  <= DFW'(fad_s1[0]) + DFW'(fad_s1[1]) + DFW'(fad_s1[2]);
			dn_s2  <= DFW'(nad_s1[0]) + DFW'(nad_s1[1]) + DFW'(nad_s1[2]);
			fn_s2  <= FNW'(fnd_s1[0]) + FNW'(fnd_s1[1]) + FNW'(fnd_s1[2]);
			deg_s2 <= far_par | near_par;
		end
	end

	// Stage 3: second-level products
	logic signed [SPW-1:0] sp_s3 [3];
	logic signed [DDW-1:0] dd_s3;
	logic signed [FNW-1:0] fn_s3;
	logic                  deg_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int k = 0; k < 3; k++) begin
				sp_s3[k] <= cx_s2[k] * a_s2[k];
			end
			dd_s3  <= df_s2 * dn_s2;
			fn_s3  <= fn_s2;
			deg_s3 <= deg_s2;
		end
	end

	// Stage 4: sine and cosine, both scaled by 2^28
	logic signed [WIDE-1:0] sn_s4, cs_s4;
	logic                   deg_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sn_s4  <= (WIDE'(sp_s3[0]) + WIDE'(sp_s3[1]) + WIDE'(sp_s3[2])) <<< 14;
			cs_s4  <= (WIDE'(fn_s3) <<< 28) - WIDE'(dd_s3);
			deg_s4 <= deg_s3;
		end
	end

	// Stage 5: magnitudes and sign flags
	logic [WIDE-1:0] ux_s5, uy_s5;
	flags_t          flg_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			ux_s5 <= cs_s4[WIDE-1] ? WIDE'(-cs_s4) : WIDE'(cs_s4);
			uy_s5 <= sn_s4[WIDE-1] ? WIDE'(-sn_s4) : WIDE'(sn_s4);
			flg_s5.degenerate <= deg_s4;
			flg_s5.sn_zero    <= (sn_s4 == '0);
			flg_s5.sn_pos     <= ~sn_s4[WIDE-1] & (sn_s4 != '0);
			flg_s5.cs_zero    <= (cs_s4 == '0);
			flg_s5.cs_neg     <= cs_s4[WIDE-1];
		end
	end

	// Stage 6: shift amount that brings both below 2^40
	logic [WIDE-1:0] uor;
	logic [KW-1:0]   k_c;
	logic [KW-1:0]   k_s6;
	logic [WIDE-1:0] ux_s6, uy_s6;
	flags_t          flg_s6;

	always_comb begin
		uor = ux_s5 | uy_s5;
		k_c = '0;
		for (int j = LIM_BITS; j < WIDE; j++) begin
			if (uor[j]) k_c = KW'(j - LIM_BITS + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			k_s6   <= k_c;
			ux_s6  <= ux_s5;
			uy_s6  <= uy_s5;
			flg_s6 <= flg_s5;
		end
	end

	// Stage 7: apply the shift
	logic [WIDE-1:0]       shx, shy;
	logic signed [XW-1:0]  x_s7, y_s7;
	flags_t                flg_s7;

	assign shx = ux_s6 >> k_s6;
	assign shy = uy_s6 >> k_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			x_s7   <= signed'(XW'(shx[LIM_BITS-1:0]));
			y_s7   <= signed'(XW'(shy[LIM_BITS-1:0]));
			flg_s7 <= flg_s6;
		end
	end

	assign dn_x = x_s7;
	assign dn_y = y_s7;
	assign dn_flags = flg_s7;

endmodule

FILE: rtl/dihed_cordic.sv
// Vectoring CORDIC, one micro-rotation per pipeline stage.
// Depends on dihed_pkg for widths and the arctangent constants.
module dihed_cordic #(
	parameter int ITER = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            up_valid,
	output logic                            up_ready,
	input  logic signed [dihed_pkg::XW-1:0] up_x,
	input  logic signed [dihed_pkg::XW-1:0] up_y,
	input  dihed_pkg::flags_t               up_flags,
	output logic                            dn_valid,
	input  logic                            dn_ready,
	output logic signed [dihed_pkg::ZW-1:0] dn_z,
	output dihed_pkg::flags_t               dn_flags
);
	import dihed_pkg::*;

	logic [ITER-1:0] vld_q;
	logic [ITER:0]   adv;

	logic signed [XW-1:0] x_s [ITER+1];
	logic signed [XW-1:0] y_s [ITER+1];
	logic signed [ZW-1:0] z_s [ITER+1];
	flags_t               f_s [ITER+1];

	always_comb begin
		adv[ITER] = dn_ready;
		for (int i = ITER - 1; i >= 0; i--) begin
			adv[i] = ~vld_q[i] | adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < ITER; i++) begin
				if (adv[i]) begin
					vld_q[i] <= (i == 0) ? up_valid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign x_s[0] = up_x;
	assign y_s[0] = up_y;
	assign z_s[0] = '0;
	assign f_s[0] = up_flags;

	for (genvar g = 0; g < ITER; g++) begin : g_rot
		localparam logic signed [ZW-1:0] ANG = atan_deg16(g);
		logic signed [XW-1:0] dx, dy;

		assign dx = x_s[g] >>> g;
		assign dy = y_s[g] >>> g;

		always_ff @(posedge clk) begin
			if (adv[g]) begin
				if (!y_s[g][XW-1]) begin
					x_s[g+1] <= x_s[g] + dy;
					y_s[g+1] <= y_s[g] - dx;
					z_s[g+1] <= z_s[g] + ANG;
				end else begin
					x_s[g+1] <= x_s[g] - dy;
					y_s[g+1] <= y_s[g] + dx;
					z_s[g+1] <= z_s[g] - ANG;
				end
				f_s[g+1] <= f_s[g];
			end
		end
	end

	assign up_ready = adv[0];
	assign dn_valid = vld_q[ITER-1];
	assign dn_z = z_s[ITER];
	assign dn_flags = f_s[ITER];

endmodule

FILE: rtl/dihed_back.sv
// Quadrant correction, special cases, rounding and the output register.
// Depends on dihed_pkg.
module dihed_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            up_valid,
	output logic                            up_ready,
	input  logic signed [dihed_pkg::ZW-1:0] up_z,
	input  dihed_pkg::flags_t               up_flags,
	output logic                            dn_valid,
	input  logic                            dn_ready,
	output dihed_pkg::result_t              dn_data
);
	import dihed_pkg::*;

	logic            vld_q;
	logic            adv;
	logic [TW-1:0]   z_c, th_base, th;
	logic [TW:0]     rsum;
	logic [15:0]     r_raw, r_c;
	result_t         res;
	result_t         res_q;

	assign adv = ~vld_q | dn_ready;

	always_comb begin
		if (up_z[ZW-1]) begin
			z_c = '0;
		end else if (up_z > DEG90_Z) begin
			z_c = DEG90_T;
		end else begin
			z_c = up_z[TW-1:0];
		end
		if (up_flags.sn_zero) begin
			th_base = '0;
		end else if (up_flags.cs_zero) begin
			th_base = DEG90_T;
		end else begin
			th_base = z_c;
		end
		th = up_flags.cs_neg ? DEG180_T - th_base : th_base;
		rsum = (TW+1)'(th) + ROUND_HALF;
		r_raw = 16'(rsum >> 9);
		r_c = (r_raw > ANG_MAX) ? ANG_MAX : r_raw;
		res.degenerate = up_flags.degenerate;
		if (up_flags.degenerate) begin
			res.angle_deg = '0;
		end else if (up_flags.sn_pos) begin
			res.angle_deg = -$signed(r_c);
		end else begin
			res.angle_deg = $signed(r_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign up_ready = adv;
	assign dn_valid = vld_q;
	assign dn_data = res_q;

endmodule

FILE: tb/tb_dihedral_angle_about_axis_unit.sv
// Testbench for dihedral_angle_about_axis_unit: directed table plus random transactions,
// checked against table values or an in-bench integer/CORDIC predictor of the torsion angle.
// Depends on dihed_pkg and the unit's RTL.
module tb_dihedral_angle_about_axis_unit;
	import dihed_pkg::*;

	localparam int NUM_RANDOM = 1530;
	localparam int ITERS = 16;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		item_t   stim;
		logic    known;
		result_t want;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	result_t angle_queue[$];
	dir_row_t dir_rows[$];
	int      mismatches;
	longint  cycles;
	bit      stim_done;
	bit      hold_long;

	dihedral_angle_about_axis_unit #(.ANGLE_ITERATIONS(ITERS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sat_axis(logic signed [15:0] v);
		longint x;
		x = v;
		if (x > AXIS_ONE) return AXIS_ONE;
		if (x < -AXIS_ONE) return -AXIS_ONE;
		return x;
	endfunction

	function automatic longint atan_step(int i);
		longint t [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return t[i];
	endfunction

	// first-quadrant angle, units of 2^-16 degree
	function automatic longint first_quadrant(longint ux, longint uy);
		longint x, y, z, dx, dy;
		z = 0;
		while (ux >= (64'sd1 <<< 40) || uy >= (64'sd1 <<< 40)) begin
			ux = ux >>> 1;
			uy = uy >>> 1;
		end
		x = ux;
		y = uy;
		for (int i = 0; i < ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		if (z < 0) z = 0;
		if (z > 90 * 65536) z = 90 * 65536;
		return z;
	endfunction

	function automatic result_t torsion_angle(item_t s);
		longint ax, ay, az, fx, fy, fz, nx, ny, nz;
		longint cx, cy, cz, df, dn, fn, sn, cs, ang, th, m, r;
		bit far_par, near_par;
		result_t o;
		ax = sat_axis(s.axis_x); ay = sat_axis(s.axis_y); az = sat_axis(s.axis_z);
		fx = s.far_x; fy = s.far_y; fz = s.far_z;
		nx = s.near_x; ny = s.near_y; nz = s.near_z;
		far_par = (fy * az - fz * ay == 0) && (fz * ax - fx * az == 0)
			&& (fx * ay - fy * ax == 0);
		near_par = (ny * az - nz * ay == 0) && (nz * ax - nx * az == 0)
			&& (nx * ay - ny * ax == 0);
		if (far_par || near_par) begin
			o.angle_deg = '0;
			o.degenerate = 1'b1;
			return o;
		end
		cx = fy * nz - fz * ny;
		cy = fz * nx - fx * nz;
		cz = fx * ny - fy * nx;
		df = fx * ax + fy * ay + fz * az;
		dn = nx * ax + ny * ay + nz * az;
		fn = fx * nx + fy * ny + fz * nz;
		sn = (cx * ax + cy * ay + cz * az) * AXIS_ONE;
		cs = fn * (AXIS_ONE * AXIS_ONE) - df * dn;
		if (sn == 0)
			ang = cs < 0 ? -180 * 65536 : 0;
		else if (cs == 0)
			ang = sn > 0 ? 90 * 65536 : -90 * 65536;
		else begin
			th = first_quadrant(cs < 0 ? -cs : cs, sn < 0 ? -sn : sn);
			if (cs < 0) th = 180 * 65536 - th;
			ang = sn < 0 ? -th : th;
		end
		m = ang < 0 ? -ang : ang;
		r = (m + 256) >>> 9;
		if (r > 23040) r = 23040;
		if (ang > 0) r = -r;
		o.angle_deg = 16'(r);
		o.degenerate = 1'b0;
		return o;
	endfunction

	function automatic item_t mk(int ax, int ay, int az, int fx, int fy, int fz,
			int nx, int ny, int nz);
		item_t s;
		s.axis_x = 16'(ax); s.axis_y = 16'(ay); s.axis_z = 16'(az);
		s.far_x = 16'(fx); s.far_y = 16'(fy); s.far_z = 16'(fz);
		s.near_x = 16'(nx); s.near_y = 16'(ny); s.near_z = 16'(nz);
		return s;
	endfunction

	function automatic int rnd16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int rnd_axis();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic int short_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
			: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
	endfunction

	task automatic add_row(item_t s, logic known, int ang, logic degen);
		dir_row_t r;
		r.stim = s;
		r.known = known;
		r.want.angle_deg = 16'(ang);
		r.want.degenerate = degen;
		dir_rows.push_back(r);
	endtask

	task automatic send_item(item_t s, logic known, result_t want);
		item_valid <= 1'b1;
		item <= s;
		do @(posedge clk); while (!item_ready);
		angle_queue.push_back(known ? want : torsion_angle(s));
	endtask

	// drop valid only when a real gap follows
	task automatic idle_for(int n);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sender
	initial begin
		item_t s;
		result_t nothing;
		int kind, g;
		nothing = '0;
		item_valid = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// axis along z: angle from far to near in the xy plane
		add_row(mk(0, 0, 16384, 100, 0, 0, 0, 100, 0), 1'b1, -11520, 1'b0);
		add_row(mk(0, 0, 16384, 0, 100, 0, 100, 0, 0), 1'b1, 11520, 1'b0);
		add_row(mk(0, 0, 16384, 100, 0, 0, -100, 0, 0), 1'b1, 23040, 1'b0);
		add_row(mk(0, 0, 16384, 100, 0, 5, 300, 0, -7), 1'b1, 0, 1'b0);
		add_row(mk(0, 0, 16384, 0, 0, 500, 1, 2, 3), 1'b1, 0, 1'b1);
		add_row(mk(0, 0, 16384, 1, 2, 3, 0, 0, 0), 1'b1, 0, 1'b1);
		add_row(mk(0, 0, 0, 1, 2, 3, 4, 5, 6), 1'b1, 0, 1'b1);
		add_row(mk(16384, 0, 0, 0, 1, 0, 0, 1, 1), 1'b0, 0, 1'b0);
		add_row(mk(-16384, -16384, -16384, 32767, -32768, 1, -32768, 32767, -1),
			1'b0, 0, 1'b0);
		add_row(mk(32767, -32768, 0, 32767, 32767, -32768, -32768, -32768, 32767),
			1'b0, 0, 1'b0);
		add_row(mk(11585, 11585, 0, -32768, 0, 32767, 0, -32768, -32768), 1'b0, 0, 1'b0);
		add_row(mk(0, 16384, 0, 32767, 5, 0, -32768, -7, -1), 1'b0, 0, 1'b0);
		add_row(mk(0, 16384, 0, 32767, 5, 0, -32768, -7, 1), 1'b0, 0, 1'b0);
		add_row(mk(-1, -1, -1, -1, -1, -1, 0, -1, 1), 1'b0, 0, 1'b0);
		add_row(mk(9459, 9459, 9459, 3, -5, 2, -4, 1, 3), 1'b0, 0, 1'b0);
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want);
			idle_for(short_gap());
		end
		for (int n = 0; n < NUM_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				s = mk(rnd_axis(), rnd_axis(), rnd_axis(), rnd16(), rnd16(), rnd16(),
					rnd16(), rnd16(), rnd16());
			else if (kind == 6) begin
				// axis along a coordinate, far or near parallel to it
				g = $urandom_range(0, 1) ? 16384 : -16384;
				s = mk(0, 0, g, 0, 0, rnd16(), rnd16(), rnd16(), rnd16());
				if ($urandom_range(0, 1)) s = mk(0, 0, g, rnd16(), rnd16(), rnd16(),
					0, 0, rnd16());
			end else if (kind == 7) begin
				// coplanar, sine zero with either sign of cosine
				g = $urandom_range(1, 200);
				s = mk(0, 16384, 0, rnd16(), rnd16(), 0, 0, 0, 0);
				s.near_x = $urandom_range(0, 1) ? s.far_x : -s.far_x;
				s.near_y = rnd16();
			end else if (kind == 8) begin
				// perpendicular in plane, cosine zero
				g = $urandom_range(1, 1000);
				s = mk(16384, 0, 0, rnd16(), g, 0, rnd16(), 0, $urandom_range(0, 1)
					? g : -g);
			end else
				s = mk(rnd16(), rnd16(), rnd16(), rnd16() >>> $urandom_range(0, 14),
					rnd16() >>> 8, rnd16(), rnd16(), rnd16() >>> 12, rnd16());
			send_item(s, 1'b0, nothing);
			if (n == 400) hold_long = 1'b1;
			else if (n > 500 && n < 700) ;
			else idle_for(short_gap());
		end
		item_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver
	initial begin
		result_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				result_ready <= 1'b0;
				hold_long = 1'b0;
				repeat (200) @(posedge clk);
				result_ready <= 1'b1;
			end else if (result_ready && $urandom_range(0, 5) == 0)
				result_ready <= 1'b0;
			else if ($urandom_range(0, 30) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
				result_ready <= 1'b1;
			end else
				result_ready <= 1'b1;
		end
	end

	// compare each completed transaction against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (angle_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: angle %0d degen %0b",
						result.angle_deg, result.degenerate);
			end else begin
				want = angle_queue.pop_front();
				if (result.angle_deg !== want.angle_deg
						|| result.degenerate !== want.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: angle exp %0d got %0d, degen exp %0b got %0b",
							want.angle_deg, result.angle_deg, want.degenerate,
							result.degenerate);
				end
			end
		end
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		stim_done = 1'b0;
		hold_long = 1'b0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
			if (stim_done && angle_queue.size() == 0) begin
				repeat (8 + ITERS + 10) @(posedge clk);
				if (mismatches == 0)
					$display("All tests passed");
				else
					$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
